// ===== hw/rtl/double_ended_list_engine_defines.svh =====
// assertion macros shared by the checker
`ifndef DOUBLE_ENDED_LIST_ENGINE_DEFINES_SVH
`define DOUBLE_ENDED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, held off during reset
`define DELE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dele check failed");

// next-cycle implication, held off during reset
`define DELE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dele check failed");

`endif

// ===== hw/rtl/dele_pkg.sv =====
package dele_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int VALUE_W_DEF = 32;
  localparam int ELEM_W      = 32;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_BACK  = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_REM_BACK  = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_REVERSE   = 3'd4,
    ACT_LIST      = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_REMOVED = 2'd0,
    STAT_LISTED  = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SEND
  } state_t;

  typedef struct packed {
    logic    ins_en;
    logic    rem_en;
    logic    rev_en;
    logic    list_start;
    logic    list_next;
    logic    load_mem;
    logic    load_stat;
    status_t stat_code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } stat_t;

endpackage

// ===== hw/rtl/double_ended_list_engine.sv =====
// Double-ended list of up to LIST_DEPTH signed values held in a single-port
// ring memory, with a reverse request that only flips the direction flag.
// Inserts and reverse give no result (an insert into a full list gives
// one "full" result, offered the cycle after the accept, as is the "empty"
// result of a remove or list-all on an empty list). A remove's result
// passes through the memory read register and then the result register
// before it is offered.
// A list-all request gives one result per stored element, each read
// through the memory read register and then the result register after the
// previous transfer, the single registered read port of the memory setting
// this pace. One request is worked on at a time: in_ready is low from the
// accept of a request with results until its last result transfer.
module double_ended_list_engine #(
  parameter int LIST_DEPTH  = dele_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dele_pkg::VALUE_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dele_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [dele_pkg::ELEM_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dele_pkg::ELEM_W-1:0]  out_element,
  output logic [dele_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_last
);

  dele_pkg::cmd_t  cmd;
  dele_pkg::stat_t stat;

  dele_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dele_dp #(
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_action   (in_action),
    .in_value    (in_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_element (out_element),
    .out_status  (out_status),
    .out_last    (out_last)
  );

endmodule

// ===== hw/rtl/dele_ctrl.sv =====
module dele_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [dele_pkg::ACTION_W-1:0]     in_action,
  output logic                              in_ready,
  input  logic                              out_ready,
  output logic                              out_valid,
  input  dele_pkg::stat_t                   stat,
  output dele_pkg::cmd_t                    cmd
);

  dele_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dele_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dele_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_action) inside
            dele_pkg::ACT_INS_BACK, dele_pkg::ACT_INS_FRONT: begin
              if (stat.full) state_nxt = dele_pkg::S_SEND;
            end
            dele_pkg::ACT_REM_BACK, dele_pkg::ACT_REM_FRONT, dele_pkg::ACT_LIST: begin
              state_nxt = stat.empty ? dele_pkg::S_SEND : dele_pkg::S_LOAD;
            end
            default: state_nxt = dele_pkg::S_IDLE;
          endcase
        end
      end
      dele_pkg::S_LOAD: state_nxt = dele_pkg::S_SEND;
      dele_pkg::S_SEND: begin
        if (out_ready) state_nxt = stat.last ? dele_pkg::S_IDLE : dele_pkg::S_LOAD;
      end
      default: state_nxt = dele_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      dele_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action) inside
            dele_pkg::ACT_INS_BACK, dele_pkg::ACT_INS_FRONT: begin
              cmd.ins_en    = !stat.full;
              cmd.load_stat = stat.full;
              cmd.stat_code = dele_pkg::STAT_FULL;
            end
            dele_pkg::ACT_REM_BACK, dele_pkg::ACT_REM_FRONT: begin
              cmd.rem_en    = !stat.empty;
              cmd.load_stat = stat.empty;
              cmd.stat_code = dele_pkg::STAT_EMPTY;
            end
            dele_pkg::ACT_REVERSE: cmd.rev_en = 1'b1;
            dele_pkg::ACT_LIST: begin
              cmd.list_start = !stat.empty;
              cmd.load_stat  = stat.empty;
              cmd.stat_code  = dele_pkg::STAT_EMPTY;
            end
            default: cmd = '0;
          endcase
        end
      end
      dele_pkg::S_LOAD: cmd.load_mem = 1'b1;
      dele_pkg::S_SEND: begin
        out_valid     = 1'b1;
        cmd.list_next = out_ready && !stat.last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dele_dp.sv =====
module dele_dp #(
  parameter int LIST_DEPTH  = dele_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dele_pkg::VALUE_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dele_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [dele_pkg::ELEM_W-1:0]  in_value,
  input  dele_pkg::cmd_t                      cmd,
  output dele_pkg::stat_t                     stat,
  output logic signed [dele_pkg::ELEM_W-1:0]  out_element,
  output logic [dele_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_last
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S   = (AW+1)'(LIST_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(LIST_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(LIST_DEPTH - 1);

  logic [VALUE_WIDTH-1:0] mem [LIST_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_r;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          is_list_r;

  logic signed [dele_pkg::ELEM_W-1:0] out_element_r;
  dele_pkg::status_t                  out_status_r;
  logic                               out_last_r;

  logic [CW-1:0] pos_inc, rd_pos, rd_off;
  logic [AW-1:0] rd_slot, ins_slot, front_dec, front_inc;
  logic          ins_back, rem_back, rd_en;
  logic signed [63:0]     val_ext;
  logic [VALUE_WIDTH-1:0] store_val;
  logic [63:0]            rd_zext;

  // ring index wrap, sum stays below twice the depth
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[AW-1:0];
  endfunction

  assign val_ext   = 64'(in_value);
  assign store_val = val_ext[VALUE_WIDTH-1:0];
  assign rd_zext   = 64'(rd_r);

  assign pos_inc   = pos_r + CW'(1);
  assign ins_back  = (in_action == dele_pkg::ACT_INS_BACK) ^ rev_r;
  assign rem_back  = (in_action == dele_pkg::ACT_REM_BACK) ^ rev_r;
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - AW'(1);
  assign front_inc = ring_add(front_r, CW'(1));
  assign ins_slot  = ins_back ? ring_add(front_r, count_r) : front_dec;
  assign rd_en     = cmd.rem_en | cmd.list_start | cmd.list_next;

  // logical position to ring slot, counted from the other end when reversed
  always_comb begin
    if (cmd.list_next) begin
      rd_pos = pos_inc;
    end else if (cmd.rem_en && in_action == dele_pkg::ACT_REM_BACK) begin
      rd_pos = count_r - CW'(1);
    end else begin
      rd_pos = '0;
    end
    rd_off  = rev_r ? (count_r - CW'(1) - rd_pos) : rd_pos;
    rd_slot = ring_add(front_r, rd_off);
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    pos_nxt   = pos_r;
    if (cmd.ins_en) begin
      count_nxt = count_r + CW'(1);
      if (!ins_back) front_nxt = front_dec;
    end
    if (cmd.rem_en) begin
      count_nxt = count_r - CW'(1);
      pos_nxt   = '0;
      if (!rem_back) front_nxt = front_inc;
    end
    if (cmd.rev_en) rev_nxt = !rev_r;
    if (cmd.list_start) pos_nxt = '0;
    if (cmd.list_next) pos_nxt = pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      pos_r   <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_en) mem[ins_slot] <= store_val;
    if (rd_en) rd_r <= mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.list_start) begin
      is_list_r <= 1'b1;
    end else if (cmd.rem_en) begin
      is_list_r <= 1'b0;
    end
    if (cmd.load_mem) begin
      out_element_r <= rd_zext[dele_pkg::ELEM_W-1:0];
      out_status_r  <= is_list_r ? dele_pkg::STAT_LISTED : dele_pkg::STAT_REMOVED;
      out_last_r    <= !is_list_r || (pos_inc == count_r);
    end else if (cmd.load_stat) begin
      out_element_r <= '0;
      out_status_r  <= cmd.stat_code;
      out_last_r    <= 1'b1;
    end
  end

  assign stat.empty  = (count_r == '0);
  assign stat.full   = (count_r == DEPTH_C);
  assign stat.last   = out_last_r;
  assign out_element = out_element_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

endmodule

// ===== hw/rtl/dele_checker.sv =====
`include "double_ended_list_engine_defines.svh"

module dele_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [dele_pkg::ACTION_W-1:0]       in_action,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dele_pkg::ELEM_W-1:0]  out_element,
  input logic [dele_pkg::STATUS_W-1:0]       out_status,
  input logic                                out_last
);

  // a stalled result holds
  `DELE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_element) && $stable(out_status) && $stable(out_last))

  // no new request while a result waits
  `DELE_ASSERT_IMP(a_one_at_a_time, clk, rst_n, out_valid, !in_ready)

  // status-only results are single and carry no element
  `DELE_ASSERT_IMP(a_status_only, clk, rst_n, out_valid && (out_status == dele_pkg::STAT_EMPTY || out_status == dele_pkg::STAT_FULL), out_last && out_element == '0)

  // a remove or list always leaves something to transfer
  `DELE_ASSERT_NXT(a_busy_after, clk, rst_n, in_valid && in_ready && (in_action == dele_pkg::ACT_REM_BACK || in_action == dele_pkg::ACT_REM_FRONT || in_action == dele_pkg::ACT_LIST), !in_ready)

endmodule

bind double_ended_list_engine dele_checker u_chk (.*);

// ===== dv/tb_top.sv =====
module tb_top;
  import dele_pkg::*;

  localparam int LIST_SLOTS     = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 360;
  localparam int QUIET_ITEMS    = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  // action codes the block has to ignore
  localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } traffic_mix_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [ELEM_W-1:0]   val;
    bit                  pinned;
    logic [ELEM_W-1:0]   pin_element;
    status_t             pin_status;
  } request_t;

  typedef struct {
    logic [ELEM_W-1:0] element;
    status_t           status;
    logic              last;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [ACTION_W-1:0]        in_action = ACT_REVERSE;
  logic signed [ELEM_W-1:0]   in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [ELEM_W-1:0]   out_element;
  logic [STATUS_W-1:0]        out_status;
  logic                       out_last;

  double_ended_list_engine #(
    .LIST_DEPTH  (LIST_SLOTS),
    .VALUE_WIDTH (VALUE_W_DEF)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_element (out_element),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the list: ring slots, physical head, occupancy, direction
  logic [ELEM_W-1:0] ring_mem [LIST_SLOTS];
  logic [5:0]        head_slot = '0;
  logic [6:0]        fill_count = '0;
  bit                flipped = 1'b0;

  result_t  pending_results [$];
  request_t offered_reqs [$];
  int       fail_count = 0;
  int       random_sent = 0;
  int       stall_cycles = 0;
  bit       hold_req = 1'b0;
  bit       quiet = 1'b0;

  function automatic void push_result(input logic [ELEM_W-1:0] el, input status_t st,
                                      input logic lst);
    result_t r;
    r.element = el;
    r.status  = st;
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_request(input logic [ACTION_W-1:0] act,
                                        input logic [ELEM_W-1:0] val);
    logic [5:0]        slot;
    logic [ELEM_W-1:0] taken;
    bit                at_back;
    case (act)
      ACT_INS_BACK, ACT_INS_FRONT: begin
        if (fill_count >= 7'(LIST_SLOTS)) begin
          push_result('0, STAT_FULL, 1'b1);
        end else begin
          // logical back is the physical back unless reversed
          at_back = (act == ACT_INS_BACK) != flipped;
          if (at_back) begin
            slot = head_slot + fill_count[5:0];
            ring_mem[slot] = val;
          end else begin
            head_slot = head_slot - 6'd1;
            ring_mem[head_slot] = val;
          end
          fill_count++;
        end
      end
      ACT_REM_BACK, ACT_REM_FRONT: begin
        if (fill_count == 0) begin
          push_result('0, STAT_EMPTY, 1'b1);
        end else begin
          at_back = (act == ACT_REM_BACK) != flipped;
          if (at_back) begin
            slot = head_slot + fill_count[5:0] - 6'd1;
            taken = ring_mem[slot];
          end else begin
            taken = ring_mem[head_slot];
            head_slot = head_slot + 6'd1;
          end
          fill_count--;
          push_result(taken, STAT_REMOVED, 1'b1);
        end
      end
      ACT_REVERSE: flipped = !flipped;
      ACT_LIST: begin
        if (fill_count == 0) begin
          push_result('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < fill_count; i++) begin
            slot = flipped ? head_slot + 6'(fill_count - 1 - i) : head_slot + 6'(i);
            push_result(ring_mem[slot], STAT_LISTED, (i == fill_count - 1));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // input side first, so a same-edge result still pops the older request
  always @(posedge clk) begin
    request_t req;
    result_t  want;
    int       before_n;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        req = offered_reqs.pop_front();
        before_n = pending_results.size();
        apply_request(in_action, in_value);
        if (req.pinned) begin
          while (pending_results.size() > before_n) void'(pending_results.pop_back());
          push_result(req.pin_element, req.pin_status, 1'b1);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: element %0d status %0d last %0d",
                 out_element, out_status, out_last);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_element !== want.element) begin
            $error("element: expected %0d, got %0d", $signed(want.element), out_element);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random back-pressure bursts, one long hold-off on request
  initial begin
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
        gap_left = 0;
      end else if (gap_left > 0 && !quiet) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 8);
      end
    end
  end

  task automatic offer(input request_t rq);
    offered_reqs.push_back(rq);
    in_valid  <= 1'b1;
    in_action <= rq.act;
    in_value  <= rq.val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_gap(input bit calm);
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // sender stops until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic request_t pick_request(input traffic_mix_t mix);
    request_t rq;
    int       r;
    int       ins_lim;
    int       rem_lim;
    int       rev_lim;
    int       lst_lim;
    case (mix)
      MIX_FILL:  begin ins_lim = 85; rem_lim = 92; rev_lim = 96; lst_lim = 98; end
      MIX_DRAIN: begin ins_lim = 15; rem_lim = 85; rev_lim = 92; lst_lim = 96; end
      default:   begin ins_lim = 40; rem_lim = 75; rev_lim = 87; lst_lim = 97; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_lim)      rq.act = $urandom_range(0, 1) ? ACT_INS_BACK : ACT_INS_FRONT;
    else if (r < rem_lim) rq.act = $urandom_range(0, 1) ? ACT_REM_BACK : ACT_REM_FRONT;
    else if (r < rev_lim) rq.act = ACT_REVERSE;
    else if (r < lst_lim) rq.act = ACT_LIST;
    else                  rq.act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
    case ($urandom_range(0, 9))
      0:       rq.val = 32'h8000_0000;
      1:       rq.val = 32'h7FFF_FFFF;
      2:       rq.val = 32'h0000_0000;
      3:       rq.val = 32'hFFFF_FFFF;
      default: rq.val = $urandom;
    endcase
    rq.pinned      = 1'b0;
    rq.pin_element = '0;
    rq.pin_status  = STAT_REMOVED;
    return rq;
  endfunction

  task automatic run_phase(input traffic_mix_t mix, input int n);
    request_t rq;
    int       done;
    bit       calm;
    done = 0;
    calm = ($urandom_range(0, 3) == 0);
    while (done < n) begin
      rq = pick_request(mix);
      offer(rq);
      // ignored codes do not count towards the item total
      if (rq.act != ACT_SPARE6 && rq.act != ACT_SPARE7) begin
        done++;
        random_sent++;
      end
      maybe_gap(calm);
    end
  endtask

  initial begin
    request_t walk_rows [25];
    walk_rows = '{
      '{ACT_REM_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{ACT_REM_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{ACT_LIST,      32'h1234_5678, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{ACT_REVERSE,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_REM_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{ACT_LIST,      32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{ACT_REVERSE,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_SPARE6,    32'hDEAD_BEEF, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_SPARE7,    32'h8000_0001, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_INS_BACK,  32'h7FFF_FFFF, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_REM_FRONT, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STAT_REMOVED},
      '{ACT_INS_FRONT, 32'h8000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      // back removal with exactly one element stored
      '{ACT_REM_BACK,  32'h0000_0000, 1'b1, 32'h8000_0000, STAT_REMOVED},
      '{ACT_REM_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY},
      '{ACT_INS_BACK,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_INS_BACK,  32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_INS_FRONT, 32'h0000_0001, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_LIST,      32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_REVERSE,   32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_LIST,      32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_INS_FRONT, 32'h5555_5555, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_INS_BACK,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_REM_FRONT, 32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_REM_BACK,  32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED},
      '{ACT_LIST,      32'h0000_0000, 1'b0, 32'h0000_0000, STAT_REMOVED}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (walk_rows[i]) begin
      offer(walk_rows[i]);
      maybe_gap(1'b0);
    end
    settle();

    // fill towards full, then stall the result side while requests keep coming
    run_phase(MIX_FILL, 90);
    hold_req = 1'b1;
    run_phase(MIX_DRAIN, 12);
    settle();
    run_phase(MIX_DRAIN, 90);
    settle();
    run_phase(MIX_FILL, 90);
    settle();
    while (random_sent < RANDOM_ITEMS - QUIET_ITEMS) begin
      run_phase(traffic_mix_t'($urandom_range(0, 2)), $urandom_range(20, 60));
      settle();
    end

    quiet = 1'b1;
    run_phase(MIX_BALANCED, QUIET_ITEMS);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
